>>> rtl/m3i_pkg.sv
// Shared types, constants and status codes of the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
package m3i_pkg;

	localparam int DW = 33;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;

	typedef logic [8:0][31:0] mat_t;

	typedef struct packed {
		logic [8:0][63:0] mag;
		logic [8:0]       neg;
	} cof_t;

	typedef struct packed {
		cof_t             cof;
		logic [2:0][31:0] m0mag;
		logic [2:0]       m0neg;
	} cofo_t;

	typedef struct packed {
		cof_t cof;
		logic dneg;
		logic singular;
		logic big;
	} car_t;

	typedef struct packed {
		logic [8:0][31:0] ent;
		logic [1:0]       status;
	} res_t;

	function automatic int nx(input int i);
		return (i == 2) ? 0 : i + 1;
	endfunction

endpackage

>>> rtl/m3i_mat_if.sv
// Input channel carrying one 3x3 matrix, column by column.
`timescale 1ns / 1ps
interface m3i_mat_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] c0_x, c0_y, c0_z;
	logic signed [31:0] c1_x, c1_y, c1_z;
	logic signed [31:0] c2_x, c2_y, c2_z;

	modport source(output valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
		input ready);
	modport sink(input valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
		output ready);
endinterface

>>> rtl/m3i_inv_if.sv
// Output channel carrying the inverse matrix and its status.
`timescale 1ns / 1ps
interface m3i_inv_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] i0_x, i0_y, i0_z;
	logic signed [31:0] i1_x, i1_y, i1_z;
	logic signed [31:0] i2_x, i2_y, i2_z;
	logic [1:0]         status;

	modport source(output valid, i0_x, i0_y, i0_z, i1_x, i1_y, i1_z, i2_x, i2_y, i2_z,
		status, input ready);
	modport sink(input valid, i0_x, i0_y, i0_z, i1_x, i1_y, i1_z, i2_x, i2_y, i2_z,
		status, output ready);
endinterface

>>> rtl/matrix3_inverse_top.sv
// Top level of the 3x3 matrix inverse: pipeline stages and a two-entry output buffer.
//
//   channel  dir  payload                          transfer when
//   mat      in   c0_x..c2_z, 32-bit Q16.16        mat.valid && mat.ready
//   inv      out  i0_x..i2_z Q16.16, status[1:0]   inv.valid && inv.ready
//
// One matrix is taken every cycle while the output buffer has a free entry.
// The reciprocal divider has 33 stages, one quotient bit per stage.
// All stages advance together whenever the output buffer has a free entry.
// The buffer keeps mat.ready independent of inv.ready; a stall loses nothing.
// Reset clears the valid bits, the buffer pointers and the buffer count only.
`timescale 1ns / 1ps
module matrix3_inverse_top import m3i_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	m3i_mat_if.sink     mat,
	m3i_inv_if.source   inv
);

	logic en;
	mat_t mat_d;
	logic cof_v, det_v, rcp_v, scl_v;
	cofo_t cof_d;
	car_t det_car, rcp_car;
	logic [DW-1:0] det_div, rcp_quo;
	res_t scl_res;
	res_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;
	res_t head;

	assign mat_d = {mat.c2_z, mat.c2_y, mat.c2_x, mat.c1_z, mat.c1_y, mat.c1_x,
		mat.c0_z, mat.c0_y, mat.c0_x};

	assign en        = cnt_q != 2'd2;
	assign mat.ready = en;

	m3i_cofactor u_cof (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(mat.valid), .mat(mat_d),
		.out_valid(cof_v), .out_data(cof_d)
	);

	m3i_det u_det (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cof_v), .in_data(cof_d),
		.out_valid(det_v), .out_car(det_car), .out_div(det_div)
	);

	m3i_recip u_rcp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(det_v), .in_car(det_car),
		.in_div(det_div), .out_valid(rcp_v), .out_car(rcp_car), .out_quo(rcp_quo)
	);

	m3i_scale u_scl (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(rcp_v), .in_car(rcp_car),
		.in_quo(rcp_quo), .out_valid(scl_v), .out_res(scl_res)
	);

	assign push = en && scl_v;
	assign pop  = inv.valid && inv.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= scl_res;
		end
	end

	assign head       = buf_q[rd_q];
	assign inv.valid  = cnt_q != 2'd0;
	assign inv.i0_x   = head.ent[0];
	assign inv.i0_y   = head.ent[1];
	assign inv.i0_z   = head.ent[2];
	assign inv.i1_x   = head.ent[3];
	assign inv.i1_y   = head.ent[4];
	assign inv.i1_z   = head.ent[5];
	assign inv.i2_x   = head.ent[6];
	assign inv.i2_y   = head.ent[7];
	assign inv.i2_z   = head.ent[8];
	assign inv.status = head.status;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("output buffer count out of range");
	a_singular_identity: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.status == ST_SINGULAR |-> inv.i0_x == ONE_Q16 &&
		inv.i1_y == ONE_Q16 && inv.i2_z == ONE_Q16 && inv.i0_y == '0 && inv.i1_x == '0)
		else $error("singular result is not the identity");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid |-> inv.status != 2'd3)
		else $error("undefined status code");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2)
		else $error("buffer changed while full and not read");
`endif

endmodule

>>> rtl/m3i_cofactor.sv
// Cofactor stages: eighteen products, then nine exact cofactors as sign and magnitude.
`timescale 1ns / 1ps
module m3i_cofactor import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  mat_t  mat,
	output logic  out_valid,
	output cofo_t out_data
);

	logic signed [63:0] p_d [9];
	logic signed [63:0] q_d [9];
	logic signed [63:0] p_s1 [9];
	logic signed [63:0] q_s1 [9];
	logic signed [2:0][31:0] m0_s1;
	logic vld_s1;
	logic vld_s2;
	cofo_t data_s2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				p_d[c*3+r] = $signed(mat[nx(r)*3+nx(c)]) * $signed(mat[nx(nx(r))*3+nx(nx(c))]);
				q_d[c*3+r] = $signed(mat[nx(r)*3+nx(nx(c))]) * $signed(mat[nx(nx(r))*3+nx(c)]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				p_s1[k] <= p_d[k];
				q_s1[k] <= q_d[k];
			end
			for (int c = 0; c < 3; c++) begin
				m0_s1[c] <= mat[c];
			end
			for (int k = 0; k < 9; k++) begin
				data_s2.cof.neg[k] <= p_s1[k] < q_s1[k];
				data_s2.cof.mag[k] <= (p_s1[k] < q_s1[k]) ? 64'(q_s1[k] - p_s1[k])
					: 64'(p_s1[k] - q_s1[k]);
			end
			for (int c = 0; c < 3; c++) begin
				data_s2.m0neg[c] <= m0_s1[c][31];
				data_s2.m0mag[c] <= m0_s1[c][31] ? 32'(-m0_s1[c]) : m0_s1[c];
			end
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = data_s2;

endmodule

>>> rtl/m3i_det.sv
// Determinant stages: split products, signed terms, sum, then magnitude and divisor.
`timescale 1ns / 1ps
module m3i_det import m3i_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cofo_t         in_data,
	output logic          out_valid,
	output car_t          out_car,
	output logic [DW-1:0] out_div
);

	logic [63:0] pl_s1 [3];
	logic [63:0] ph_s1 [3];
	logic [2:0] sgn_s1;
	cof_t cof_s1, cof_s2, cof_s3;
	logic signed [98:0] term_s2 [3];
	logic signed [98:0] det_s3;
	logic [98:0] adet;
	logic [3:0] vld_q;
	car_t car_s4;
	logic [DW-1:0] div_s4;

	assign adet = det_s3[98] ? 99'(-det_s3) : 99'(det_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic [95:0] t;
		logic [98:0] tt;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pl_s1[c]  <= in_data.m0mag[c] * in_data.cof.mag[c*3][31:0];
				ph_s1[c]  <= in_data.m0mag[c] * in_data.cof.mag[c*3][63:32];
				sgn_s1[c] <= in_data.m0neg[c] ^ in_data.cof.neg[c*3];
			end
			cof_s1 <= in_data.cof;
			for (int c = 0; c < 3; c++) begin
				t  = {ph_s1[c], 32'd0} + {32'd0, pl_s1[c]};
				tt = {3'd0, t};
				term_s2[c] <= sgn_s1[c] ? -tt : tt;
			end
			cof_s2 <= cof_s1;
			det_s3 <= term_s2[0] + term_s2[1] + term_s2[2];
			cof_s3 <= cof_s2;
			car_s4.cof      <= cof_s3;
			car_s4.dneg     <= det_s3[98];
			car_s4.singular <= adet[98:32] == '0;
			car_s4.big      <= (adet[98:65] != '0) || (adet[64] && (adet[63:32] != '0));
			div_s4          <= adet[64:32];
		end
	end

	assign out_valid = vld_q[3];
	assign out_car   = car_s4;
	assign out_div   = div_s4;

endmodule

>>> rtl/m3i_recip.sv
// Reciprocal stages: restoring division of 2^32 by the divisor, one quotient bit a stage.
`timescale 1ns / 1ps
module m3i_recip import m3i_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  car_t          in_car,
	input  logic [DW-1:0] in_div,
	output logic          out_valid,
	output car_t          out_car,
	output logic [DW-1:0] out_quo
);

	logic [DW-1:0] rem_s [1:DW];
	logic [DW-1:0] quo_s [1:DW];
	logic [DW-1:0] dv_s  [1:DW];
	car_t          car_s [1:DW];
	logic          vld_s [1:DW];

	for (genvar k = 1; k <= DW; k++) begin : g_st
		logic [DW-1:0] rem_p, quo_p, dv_p;
		car_t car_p;
		logic vld_p;
		logic [DW:0] sh;
		logic ge;

		if (k == 1) begin : g_first
			assign rem_p = '0;
			assign quo_p = '0;
			assign dv_p  = in_div;
			assign car_p = in_car;
			assign vld_p = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
			assign dv_p  = dv_s[k-1];
			assign car_p = car_s[k-1];
			assign vld_p = vld_s[k-1];
		end

		assign sh = {rem_p, (k == 1) ? 1'b1 : 1'b0};
		assign ge = sh >= {1'b0, dv_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(sh - {1'b0, dv_p}) : sh[DW-1:0];
				quo_s[k] <= {quo_p[DW-2:0], ge};
				dv_s[k]  <= dv_p;
				car_s[k] <= car_p;
			end
		end
	end

	assign out_valid = vld_s[DW];
	assign out_car   = car_s[DW];
	assign out_quo   = quo_s[DW];

endmodule

>>> rtl/m3i_scale.sv
// Scaling stages: clamp the reciprocal, multiply each cofactor, truncate and saturate.
`timescale 1ns / 1ps
module m3i_scale import m3i_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  car_t          in_car,
	input  logic [DW-1:0] in_quo,
	output logic          out_valid,
	output res_t          out_res
);

	logic [31:0] rmag_s1;
	logic rsat_s1, rsat_s2, rsat_s3;
	car_t car_s1;
	logic [63:0] pl_s2 [9];
	logic [63:0] ph_s2 [9];
	logic [8:0] neg_s2, neg_s3;
	logic sing_s2, sing_s3;
	logic [63:0] q_s3 [9];
	logic [3:0] vld_q;
	res_t res_s4;
	logic [DW-1:0] rm;

	assign rm = in_car.big ? '0 : in_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic sat;
		if (en) begin
			car_s1 <= in_car;
			if (!in_car.dneg && rm > DW'(SAT_POS)) begin
				rmag_s1 <= SAT_POS;
				rsat_s1 <= 1'b1;
			end else if (in_car.dneg && rm > DW'(SAT_NEG)) begin
				rmag_s1 <= SAT_NEG;
				rsat_s1 <= 1'b1;
			end else begin
				rmag_s1 <= rm[31:0];
				rsat_s1 <= 1'b0;
			end

			for (int k = 0; k < 9; k++) begin
				pl_s2[k]  <= car_s1.cof.mag[k][31:0] * rmag_s1;
				ph_s2[k]  <= car_s1.cof.mag[k][63:32] * rmag_s1;
				neg_s2[k] <= car_s1.cof.neg[k] ^ car_s1.dneg;
			end
			sing_s2 <= car_s1.singular;
			rsat_s2 <= rsat_s1;

			for (int k = 0; k < 9; k++) begin
				q_s3[k] <= ph_s2[k] + {32'd0, pl_s2[k][63:32]};
			end
			neg_s3  <= neg_s2;
			sing_s3 <= sing_s2;
			rsat_s3 <= rsat_s2;

			sat = rsat_s3;
			for (int k = 0; k < 9; k++) begin
				if (sing_s3) begin
					res_s4.ent[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q16 : '0;
				end else if (neg_s3[k]) begin
					if (q_s3[k] > 64'(SAT_NEG)) begin
						res_s4.ent[k] <= SAT_NEG;
						sat = 1'b1;
					end else begin
						res_s4.ent[k] <= -q_s3[k][31:0];
					end
				end else begin
					if (q_s3[k] > 64'(SAT_POS)) begin
						res_s4.ent[k] <= SAT_POS;
						sat = 1'b1;
					end else begin
						res_s4.ent[k] <= q_s3[k][31:0];
					end
				end
			end
			res_s4.status <= sing_s3 ? ST_SINGULAR : (sat ? ST_SAT : ST_OK);
		end
	end

	assign out_valid = vld_q[3];
	assign out_res   = res_s4;

endmodule

>>> tb/sv/matrix3_inverse_top_test.sv
// Self-checking testbench of the 3x3 matrix inverse: directed and random matrices.
`timescale 1ns / 1ps
module matrix3_inverse_top_test;
	import m3i_pkg::*;

	typedef logic signed [31:0] q16_t;
	typedef struct {
		q16_t       ent[9];
		logic [1:0] status;
	} inverse_t;

	localparam int LATENCY = 44;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	m3i_mat_if mat();
	m3i_inv_if inv();

	matrix3_inverse_top u_dut(.clk(clk), .arst_n(arst_n), .mat(mat), .inv(inv));

	inverse_t expected_inverses[$];
	int mismatches;
	int unexpected;
	int matrices_sent;
	int inverses_seen;
	int singular_seen;
	int saturated_seen;
	longint cycles;
	bit burst_mode;
	int stall_phase;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles with %0d inverses pending.", cycles,
					expected_inverses.size());
				$display("matrix3_inverse_top test failed");
				$finish;
			end
		end
	end

	// Receiver stalls on its own pattern: a slow rotating phase mixed with random holds.
	initial begin
		inv.ready = 1'b0;
		stall_phase = 0;
		forever begin
			@(posedge clk);
			stall_phase = (stall_phase + 1) % 97;
			if (stall_phase < 30)
				inv.ready <= 1'b1;
			else if (stall_phase < 60)
				inv.ready <= ($urandom_range(0, 3) != 0);
			else if (stall_phase < 70)
				inv.ready <= 1'b0;
			else
				inv.ready <= ($urandom_range(0, 1) == 1);
		end
	end

	function automatic logic [127:0] abs128(input logic signed [127:0] v);
		return v[127] ? -v : v;
	endfunction

	function automatic inverse_t predict_inverse(input q16_t m[9]);
		inverse_t res;
		logic signed [127:0] cof[9];
		logic signed [127:0] det, prod;
		logic [127:0] dmag, rmag, cmag, qmag;
		logic dneg, rneg, eneg, sat;
		int r1, r2, c1, c2;
		logic signed [127:0] a[3][3];
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				a[r][c] = m[c * 3 + r];
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++) begin
				r1 = (r + 1) % 3;
				r2 = (r + 2) % 3;
				c1 = (c + 1) % 3;
				c2 = (c + 2) % 3;
				cof[c * 3 + r] = a[c1][r1] * a[c2][r2] - a[c2][r1] * a[c1][r2];
			end
		det = 0;
		for (int c = 0; c < 3; c++)
			det += a[c][0] * cof[c * 3];
		dneg = det[127];
		dmag = abs128(det) >> 32;
		sat = 1'b0;
		if (dmag == 0) begin
			for (int i = 0; i < 9; i++)
				res.ent[i] = (i % 4 == 0) ? ONE_Q16 : 32'd0;
			res.status = ST_SINGULAR;
			return res;
		end
		rmag = (dmag > (128'd1 << 32)) ? 128'd0 : ((128'd1 << 32) / dmag);
		rneg = dneg;
		if (!rneg && rmag > 128'h7FFF_FFFF) begin
			rmag = 128'h7FFF_FFFF;
			sat = 1'b1;
		end
		if (rneg && rmag > 128'h8000_0000) begin
			rmag = 128'h8000_0000;
			sat = 1'b1;
		end
		for (int i = 0; i < 9; i++) begin
			cmag = abs128(cof[i]);
			eneg = cof[i][127] != rneg;
			qmag = (cmag * rmag) >> 32;
			if (eneg && qmag > 128'h8000_0000) begin
				res.ent[i] = SAT_NEG;
				sat = 1'b1;
			end else if (!eneg && qmag > 128'h7FFF_FFFF) begin
				res.ent[i] = SAT_POS;
				sat = 1'b1;
			end else begin
				prod = eneg ? -$signed(qmag) : $signed(qmag);
				res.ent[i] = prod[31:0];
			end
		end
		res.status = sat ? ST_SAT : ST_OK;
		return res;
	endfunction

	// Checks every transfer on the inverse channel against the oldest prediction.
	initial begin
		inverse_t exp_inv;
		q16_t got[9];
		bit bad;
		mismatches = 0;
		unexpected = 0;
		inverses_seen = 0;
		singular_seen = 0;
		saturated_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && inv.valid && inv.ready) begin
				got = '{inv.i0_x, inv.i0_y, inv.i0_z, inv.i1_x, inv.i1_y, inv.i1_z,
					inv.i2_x, inv.i2_y, inv.i2_z};
				if (expected_inverses.size() == 0) begin
					unexpected++;
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected inverse transfer at cycle %0d.", cycles);
				end else begin
					exp_inv = expected_inverses.pop_front();
					inverses_seen++;
					if (exp_inv.status == ST_SINGULAR)
						singular_seen++;
					if (exp_inv.status == ST_SAT)
						saturated_seen++;
					bad = (inv.status !== exp_inv.status);
					for (int i = 0; i < 9; i++)
						if (got[i] !== exp_inv.ent[i])
							bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on inverse %0d: status exp %0d got %0d.",
								inverses_seen, exp_inv.status, inv.status);
							for (int i = 0; i < 9; i++)
								if (got[i] !== exp_inv.ent[i])
									$display("  entry %0d exp %h got %h", i,
										exp_inv.ent[i], got[i]);
						end
					end
				end
			end
		end
	end

	task automatic send_matrix(input q16_t m[9]);
		if (burst_mode && $urandom_range(0, 7) == 0) begin
			mat.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		mat.valid <= 1'b1;
		{mat.c0_x, mat.c0_y, mat.c0_z, mat.c1_x, mat.c1_y, mat.c1_z,
			mat.c2_x, mat.c2_y, mat.c2_z} <= {m[0], m[1], m[2], m[3], m[4], m[5],
			m[6], m[7], m[8]};
		do
			@(posedge clk);
		while (!mat.ready);
		expected_inverses.push_back(predict_inverse(m));
		matrices_sent++;
	endtask

	task automatic finish_sending();
		mat.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic q16_t random_entry(input int span);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2 * span)) - span;
			2: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
			3: return 32'sd0;
			default: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
		endcase
	endfunction

	task automatic test_directed();
		q16_t m[9];
		m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		send_matrix(m);
		m = '{32'h20000, 0, 0, 0, 32'h40000, 0, 0, 0, 32'h80000};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		// Rank-deficient: the third column repeats the first.
		m = '{32'h10000, 32'h20000, 32'h30000, 32'h5000, 32'h7000, 32'h1000,
			32'h10000, 32'h20000, 32'h30000};
		send_matrix(m);
		// Tiny nonzero determinant that truncates to zero.
		m = '{32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100};
		send_matrix(m);
		// Determinants of +1, +2 and -1 LSB overflow the reciprocal.
		m = '{32'h1, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		send_matrix(m);
		m = '{32'h2, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		send_matrix(m);
		m = '{-32'sh1, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		send_matrix(m);
		// Huge determinant gives a zero reciprocal.
		m = '{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF};
		send_matrix(m);
		m = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(m);
		m = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
		send_matrix(m);
		// Mixed scales on the diagonal; the inverse stays in range.
		m = '{32'h100, 0, 0, 0, 32'h1000000, 0, 0, 0, 32'h1000000};
		send_matrix(m);
		m = '{-32'sh10000, 32'h30000, 0, 32'h10000, -32'sh20000, 32'h10000,
			0, 32'h50000, -32'sh10000};
		send_matrix(m);
		m = '{32'h18000, 32'h8000, -32'sh4000, 32'h2000, 32'h14000, 32'h6000,
			-32'sh8000, 32'h1000, 32'h20000};
		send_matrix(m);
		finish_sending();
	endtask

	task automatic test_random(input int count, input bit bursty);
		q16_t m[9];
		int span;
		burst_mode = bursty;
		for (int n = 0; n < count; n++) begin
			span = (n % 3 == 0) ? 32'h40000 : ((n % 3 == 1) ? 32'h400000 : 32'h7FFFFFFF);
			for (int i = 0; i < 9; i++)
				m[i] = (n % 2) ? $signed($urandom_range(0, 2 * 32'h80000)) - 32'h80000 :
					random_entry(span);
			// Sometimes force a dependent column to exercise the singular path.
			if ($urandom_range(0, 9) == 0)
				for (int i = 0; i < 3; i++)
					m[6 + i] = m[i];
			send_matrix(m);
		end
		finish_sending();
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		mat.valid = 1'b0;
		{mat.c0_x, mat.c0_y, mat.c0_z, mat.c1_x, mat.c1_y, mat.c1_z,
			mat.c2_x, mat.c2_y, mat.c2_z} = '0;
		matrices_sent = 0;
		burst_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 1'b0);
		test_random(400, 1'b1);
		while (expected_inverses.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		$display("Sent %0d matrices, checked %0d inverses.", matrices_sent, inverses_seen);
		$display("Singular results: %0d, saturated results: %0d.", singular_seen,
			saturated_seen);
		if (mismatches == 0 && unexpected == 0 && expected_inverses.size() == 0)
			$display("matrix3_inverse_top test passed");
		else
			$display("matrix3_inverse_top test failed");
		$finish;
	end
endmodule
